/* rtl/b7seg_pkg.sv */
// Shared types and constants for the binary to seven-segment digit writer.
// Depends on nothing; used by binary_to_seven_segment_digits_unit.
package b7seg_pkg;

  localparam int VALUE_W    = 16;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 5;
  localparam int BCD_W      = DIGIT_W * NUM_DIGITS;
  localparam int POS_W      = 3;
  localparam int ADDR_W     = 8;
  localparam int SEG_W      = 7;

  localparam logic [ADDR_W-1:0] ADDRESS_BASE = 8'd146;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_EMIT
  } state_t;

  // Panel digit table: segment pattern for decimal digits 0..9
  function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] digit);
    logic [SEG_W-1:0] seg;
    unique case (digit)
      4'd0:    seg = 7'd95;
      4'd1:    seg = 7'd6;
      4'd2:    seg = 7'd107;
      4'd3:    seg = 7'd47;
      4'd4:    seg = 7'd54;
      4'd5:    seg = 7'd61;
      4'd6:    seg = 7'd125;
      4'd7:    seg = 7'd39;
      4'd8:    seg = 7'd127;
      4'd9:    seg = 7'd63;
      default: seg = '0;
    endcase
    return seg;
  endfunction

endpackage

/* rtl/binary_to_seven_segment_digits_unit.sv */
// Binary to seven-segment digit writer: shift-add-3 conversion, then one write per digit.
// Depends on b7seg_pkg.
//
// A word is taken when start is high and busy is low. The low NUMBER_WIDTH bits
// (at most 16) of value are shifted one bit per cycle into a five-digit BCD
// register with add-3 correction. The digits then leave one per cycle, units
// first, each on the result ports for exactly one cycle with strobe high; the
// receiver cannot stall them. Leading zeros are dropped, zero gives a single
// digit, and last_digit marks the final write. Busy stays high from acceptance
// until the last write is shown, so a new word is not taken before then.
module binary_to_seven_segment_digits_unit #(
  parameter int NUMBER_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [b7seg_pkg::VALUE_W-1:0]  value,
  output logic                           strobe,
  output logic [b7seg_pkg::POS_W-1:0]    digit_position,
  output logic [b7seg_pkg::ADDR_W-1:0]   memory_address,
  output logic [b7seg_pkg::DIGIT_W-1:0]  digit_value,
  output logic [b7seg_pkg::SEG_W-1:0]    segment_pattern,
  output logic                           last_digit
);

  localparam int EW = (NUMBER_WIDTH < b7seg_pkg::VALUE_W) ? NUMBER_WIDTH
                                                         : b7seg_pkg::VALUE_W;
  localparam int CNT_W = $clog2(EW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(EW - 1);
  localparam logic [b7seg_pkg::POS_W-1:0] POS_LAST =
    b7seg_pkg::POS_W'(b7seg_pkg::NUM_DIGITS);

  b7seg_pkg::state_t state, state_next;

  logic [EW-1:0]                  bin;
  logic [b7seg_pkg::BCD_W-1:0]    bcd;
  logic [b7seg_pkg::BCD_W-1:0]    bcd_adj;
  logic [CNT_W-1:0]               cnt;
  logic [b7seg_pkg::POS_W-1:0]    pos;
  logic                           accept;
  logic                           emit_last;

  assign accept    = start && (state == b7seg_pkg::ST_IDLE);
  assign emit_last = (bcd[b7seg_pkg::BCD_W-1:b7seg_pkg::DIGIT_W] == '0) || (pos == POS_LAST);

  // Add 3 to every digit of 5 or more before the next shift
  always_comb begin
    for (int i = 0; i < b7seg_pkg::NUM_DIGITS; i++) begin
      if (bcd[i*b7seg_pkg::DIGIT_W +: b7seg_pkg::DIGIT_W] >= 4'd5) begin
        bcd_adj[i*b7seg_pkg::DIGIT_W +: b7seg_pkg::DIGIT_W] =
          bcd[i*b7seg_pkg::DIGIT_W +: b7seg_pkg::DIGIT_W] + 4'd3;
      end else begin
        bcd_adj[i*b7seg_pkg::DIGIT_W +: b7seg_pkg::DIGIT_W] =
          bcd[i*b7seg_pkg::DIGIT_W +: b7seg_pkg::DIGIT_W];
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      b7seg_pkg::ST_IDLE: begin
        if (start) state_next = b7seg_pkg::ST_CONVERT;
      end
      b7seg_pkg::ST_CONVERT: begin
        if (cnt == CNT_LAST) state_next = b7seg_pkg::ST_EMIT;
      end
      b7seg_pkg::ST_EMIT: begin
        if (emit_last) state_next = b7seg_pkg::ST_IDLE;
      end
      default: state_next = b7seg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= b7seg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bin <= value[EW-1:0];
      bcd <= '0;
      cnt <= '0;
      pos <= b7seg_pkg::POS_W'(1);
    end else if (state == b7seg_pkg::ST_CONVERT) begin
      // shift the next binary bit into the corrected BCD register
      bcd <= {bcd_adj[b7seg_pkg::BCD_W-2:0], bin[EW-1]};
      bin <= {bin[EW-2:0], 1'b0};
      cnt <= cnt + CNT_W'(1);
    end else if (state == b7seg_pkg::ST_EMIT) begin
      // drop the digit just shown, advance to the next place
      bcd <= {{b7seg_pkg::DIGIT_W{1'b0}}, bcd[b7seg_pkg::BCD_W-1:b7seg_pkg::DIGIT_W]};
      pos <= pos + b7seg_pkg::POS_W'(1);
    end
  end

  always_comb begin
    busy            = (state != b7seg_pkg::ST_IDLE);
    strobe          = (state == b7seg_pkg::ST_EMIT);
    digit_position  = pos;
    memory_address  = b7seg_pkg::ADDRESS_BASE +
                      {{(b7seg_pkg::ADDR_W-b7seg_pkg::POS_W){1'b0}}, pos};
    digit_value     = bcd[b7seg_pkg::DIGIT_W-1:0];
    segment_pattern = b7seg_pkg::seg_of(bcd[b7seg_pkg::DIGIT_W-1:0]);
    last_digit      = emit_last;
  end

endmodule

/* dv/tb_binary_to_seven_segment_digits_unit.sv */
// Testbench for binary_to_seven_segment_digits_unit: drives numbers, predicts each digit write.
// Depends on b7seg_pkg and the unit's RTL; a small scoreboard class holds the pending writes.
module tb_binary_to_seven_segment_digits_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_W    = b7seg_pkg::VALUE_W;
  localparam int DIGIT_W    = b7seg_pkg::DIGIT_W;
  localparam int NUM_DIGITS = b7seg_pkg::NUM_DIGITS;
  localparam int POS_W      = b7seg_pkg::POS_W;
  localparam int ADDR_W     = b7seg_pkg::ADDR_W;
  localparam int SEG_W      = b7seg_pkg::SEG_W;
  localparam logic [ADDR_W-1:0] ADDRESS_BASE = b7seg_pkg::ADDRESS_BASE;

  localparam int NUMBER_WIDTH = 16;
  localparam int QUIET_LIMIT  = 2000;
  localparam int ITEMS_PER_PHASE = 37;

  localparam logic [SEG_W-1:0] DIGIT_SEGMENTS [10] = '{
    7'd95, 7'd6, 7'd107, 7'd47, 7'd54, 7'd61, 7'd125, 7'd39, 7'd127, 7'd63
  };

  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic [ADDR_W-1:0]  addr;
    logic [DIGIT_W-1:0] digit;
    logic [SEG_W-1:0]   seg;
    logic               is_last;
  } digit_write_t;

  class digit_write_tracker;
    digit_write_t pending_writes[$];
    int unsigned  failures;

    function new();
      failures = 0;
    endfunction

    // Expand an accepted number into its digit writes, units first.
    function void note_value(logic [VALUE_W-1:0] number);
      logic [VALUE_W-1:0] rest;
      logic [DIGIT_W-1:0] d;
      digit_write_t       w;
      int unsigned        place;
      rest  = number & VALUE_W'((64'd1 << NUMBER_WIDTH) - 64'd1);
      place = 0;
      do begin
        d     = DIGIT_W'(rest % 10);
        rest  = VALUE_W'(rest / 10);
        place = place + 1;
        w.pos     = POS_W'(place);
        w.addr    = ADDRESS_BASE + ADDR_W'(place);
        w.digit   = d;
        w.seg     = DIGIT_SEGMENTS[d];
        w.is_last = (rest == 0) || (place >= NUM_DIGITS);
        pending_writes.push_back(w);
      end while (rest != 0 && place < NUM_DIGITS);
    endfunction

    function void check_write(logic [POS_W-1:0] pos, logic [ADDR_W-1:0] addr,
                              logic [DIGIT_W-1:0] digit, logic [SEG_W-1:0] seg,
                              logic is_last);
      digit_write_t w;
      if (pending_writes.size() == 0) begin
        $error("unexpected digit write: position %0d digit %0d", pos, digit);
        failures++;
        return;
      end
      w = pending_writes.pop_front();
      if (pos !== w.pos) begin
        $error("digit_position: expected %0d, got %0d", w.pos, pos);
        failures++;
      end
      if (addr !== w.addr) begin
        $error("memory_address: expected %0d, got %0d", w.addr, addr);
        failures++;
      end
      if (digit !== w.digit) begin
        $error("digit_value: expected %0d, got %0d", w.digit, digit);
        failures++;
      end
      if (seg !== w.seg) begin
        $error("segment_pattern: expected %0d, got %0d", w.seg, seg);
        failures++;
      end
      if (is_last !== w.is_last) begin
        $error("last_digit: expected %0d, got %0d", w.is_last, is_last);
        failures++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [VALUE_W-1:0]  value;
  logic                strobe;
  logic [POS_W-1:0]    digit_position;
  logic [ADDR_W-1:0]   memory_address;
  logic [DIGIT_W-1:0]  digit_value;
  logic [SEG_W-1:0]    segment_pattern;
  logic                last_digit;

  digit_write_tracker tracker = new();
  int unsigned        quiet_cycles;

  binary_to_seven_segment_digits_unit #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .value(value),
    .strobe(strobe),
    .digit_position(digit_position),
    .memory_address(memory_address),
    .digit_value(digit_value),
    .segment_pattern(segment_pattern),
    .last_digit(last_digit)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Check writes before noting a new word, so a stray write is never hidden.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (strobe)
        tracker.check_write(digit_position, memory_address, digit_value,
                            segment_pattern, last_digit);
      if (start && !busy)
        tracker.note_value(value);
      if (strobe || (start && !busy)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[binary_to_seven_segment_digits_unit] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one word, possibly after a random gap; return at the falling edge after it is taken.
  task automatic send_word(input logic [VALUE_W-1:0] number, input int unsigned idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 24)) @(negedge clk);
    end
    start = 1'b1;
    value = number;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Hold off until every pending digit write has been shown.
  task automatic drain_writes();
    start = 1'b0;
    while (tracker.pending_writes.size() != 0) @(negedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_number();
    case ($urandom_range(0, 5))
      0:       return VALUE_W'($urandom_range(0, 9));
      1:       return VALUE_W'($urandom_range(10, 99));
      2:       return VALUE_W'($urandom_range(100, 999));
      3:       return VALUE_W'($urandom_range(1000, 9999));
      4:       return VALUE_W'($urandom_range(10000, 65535));
      default: return VALUE_W'($urandom());
    endcase
  endfunction

  initial begin
    logic [VALUE_W-1:0] directed [$];
    int unsigned        idle_pcts [4];
    rst   = 1'b1;
    start = 1'b0;
    value = '0;
    directed = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd90, 16'd99, 16'd100, 16'd999,
                 16'd1000, 16'd9999, 16'd10000, 16'd10001, 16'd40000, 16'd12345,
                 16'd16789, 16'd54321, 16'd32768, 16'd21845, 16'd43690, 16'd65534,
                 16'd65535};
    idle_pcts = '{0, 45, 0, 37};
    repeat (9) @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) send_word(directed[i], 0);
    drain_writes();

    foreach (idle_pcts[p]) begin
      repeat (ITEMS_PER_PHASE) send_word(pick_number(), idle_pcts[p]);
      drain_writes();
    end

    // Let any late write show up before judging.
    repeat (30) @(negedge clk);
    if (tracker.failures == 0 && tracker.pending_writes.size() == 0) begin
      $display("[binary_to_seven_segment_digits_unit] OK");
    end else begin
      $display("[binary_to_seven_segment_digits_unit] ERROR");
    end
    $finish;
  end

endmodule
